FILE: rtl/core/positional_pid_integral_separation_macros.svh
// assertion macros for the positional pid block checker
// used by ppis_checker only, no other dependencies
`ifndef POSITIONAL_PID_INTEGRAL_SEPARATION_MACROS_SVH
`define POSITIONAL_PID_INTEGRAL_SEPARATION_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define PPIS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ppis checker: same-cycle property failed");

// consequent must hold in the cycle after the antecedent
`define PPIS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ppis checker: next-cycle property failed");

`endif

FILE: rtl/core/ppis_pkg.sv
// shared types, widths and codes of the positional pid block
// no dependencies; imported by every module of the block
package ppis_pkg;

    // sample and datapath widths
    localparam int SAMPLE_BITS = 16;
    localparam int ERR_W       = SAMPLE_BITS + 1;
    localparam int DIFF_W      = SAMPLE_BITS + 2;
    localparam int GAIN_W      = 32;
    localparam int SUM_W       = 32;
    localparam int ILIM_W      = 31;
    localparam int DLIM_W      = 47;
    localparam int THR_W       = 16;
    localparam int DRIVE_W     = 48;
    localparam int S_DATA_W    = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W    = ((DRIVE_W + 7) / 8) * 8;

    // shared multiplier and fraction datapath
    localparam int MUL_W       = 33;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 64;
    localparam int ABS_W       = 63;
    localparam int LO_SHIFT    = MUL_W - 1;
    localparam int LO_PROD_W   = LO_SHIFT + THR_W;
    localparam int DIV_W       = ABS_W + THR_W;
    localparam int CNT_W       = $clog2(DIV_W + 1);

    // apb port
    localparam int APB_DATA_W  = 64;
    localparam int APB_ADDR_W  = 6;
    localparam int REG_IDX_W   = 3;
    localparam int REG_IDX_LSB = 3;

    // register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_GAIN_P,
        REG_GAIN_I,
        REG_GAIN_D,
        REG_INTEGRAL_LIMIT,
        REG_DRIVE_LIMIT,
        REG_SEPARATION_ENABLE,
        REG_BEGIN_THRESHOLD,
        REG_FULL_THRESHOLD
    } ppis_reg_idx_t;

    // integral term selection
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_FULL,
        KIND_FRAC
    } ppis_kind_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_I,
        ST_I_TERM,
        ST_FRAC_LO,
        ST_FRAC_HI,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OUT
    } ppis_state_t;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [ILIM_W-1:0]        integral_limit;
        logic [DLIM_W-1:0]        drive_limit;
        logic                     separation_enable;
        logic [THR_W-1:0]         begin_threshold;
        logic [THR_W-1:0]         full_threshold;
    } ppis_cfg_t;

    // multiplier operands
    typedef struct packed {
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } ppis_mul_req_t;

    // divider request and response
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [THR_W-1:0] divisor;
    } ppis_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } ppis_div_rsp_t;

endpackage

FILE: rtl/core/ppis_regs.sv
// apb configuration registers of the positional pid block
// depends on ppis_pkg
module ppis_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ppis_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ppis_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ppis_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output ppis_pkg::ppis_cfg_t            cfg
);
    import ppis_pkg::*;

    ppis_cfg_t     cfg_reg;
    ppis_reg_idx_t idx;
    logic          wr_en;

    assign pready = 1'b1;
    assign idx    = ppis_reg_idx_t'(paddr[REG_IDX_LSB +: REG_IDX_W]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_GAIN_P:            cfg_reg.gain_p <= $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_I:            cfg_reg.gain_i <= $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_D:            cfg_reg.gain_d <= $signed(pwdata[GAIN_W-1:0]);
                REG_INTEGRAL_LIMIT:    cfg_reg.integral_limit <= pwdata[ILIM_W-1:0];
                REG_DRIVE_LIMIT:       cfg_reg.drive_limit <= pwdata[DLIM_W-1:0];
                REG_SEPARATION_ENABLE: cfg_reg.separation_enable <= pwdata[0];
                REG_BEGIN_THRESHOLD:   cfg_reg.begin_threshold <= pwdata[THR_W-1:0];
                REG_FULL_THRESHOLD:    cfg_reg.full_threshold <= pwdata[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read mux, values zero extended
    always_comb begin
        case (idx)
            REG_GAIN_P:            prdata = APB_DATA_W'($unsigned(cfg_reg.gain_p));
            REG_GAIN_I:            prdata = APB_DATA_W'($unsigned(cfg_reg.gain_i));
            REG_GAIN_D:            prdata = APB_DATA_W'($unsigned(cfg_reg.gain_d));
            REG_INTEGRAL_LIMIT:    prdata = APB_DATA_W'(cfg_reg.integral_limit);
            REG_DRIVE_LIMIT:       prdata = APB_DATA_W'(cfg_reg.drive_limit);
            REG_SEPARATION_ENABLE: prdata = APB_DATA_W'(cfg_reg.separation_enable);
            REG_BEGIN_THRESHOLD:   prdata = APB_DATA_W'(cfg_reg.begin_threshold);
            REG_FULL_THRESHOLD:    prdata = APB_DATA_W'(cfg_reg.full_threshold);
            default:               prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/ppis_mul.sv
// shared signed multiplier with registered product
// depends on ppis_pkg
module ppis_mul (
    input  logic                              aclk,
    input  ppis_pkg::ppis_mul_req_t           req,
    output logic signed [ppis_pkg::PROD_W-1:0] prod
);
    import ppis_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // one product per cycle, ready the cycle after the operands
    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/ppis_div.sv
// restoring serial divider, one quotient bit per cycle
// depends on ppis_pkg
module ppis_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ppis_pkg::ppis_div_req_t req,
    output ppis_pkg::ppis_div_rsp_t rsp
);
    import ppis_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [THR_W-1:0] rem_reg;
    logic [THR_W-1:0] rem_next;
    logic [THR_W-1:0] divisor_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [DIV_W-1:0] quo_next;
    logic [THR_W:0]   shifted;
    logic [THR_W:0]   trial;

    // shift in the next dividend bit and try the subtract
    always_comb begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        trial   = shifted - {1'b0, divisor_reg};
        if (shifted >= {1'b0, divisor_reg}) begin
            rem_next = trial[THR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b1};
        end else begin
            rem_next = shifted[THR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], 1'b0};
        end
    end

    // control: busy over all dividend bits, done pulse at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !req.start && busy_reg && (cnt_reg == CNT_W'(DIV_W - 1));
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/core/ppis_ctrl.sv
// sequencer and datapath of the positional pid block
// depends on ppis_pkg; drives ppis_mul and ppis_div
module ppis_ctrl (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  ppis_pkg::ppis_cfg_t                    cfg,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [ppis_pkg::SAMPLE_BITS-1:0] target,
    input  logic signed [ppis_pkg::SAMPLE_BITS-1:0] measured,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [ppis_pkg::DRIVE_W-1:0]    drive,
    output ppis_pkg::ppis_mul_req_t                mul_req,
    input  logic signed [ppis_pkg::PROD_W-1:0]     mul_prod,
    output ppis_pkg::ppis_div_req_t                div_req,
    input  ppis_pkg::ppis_div_rsp_t                div_rsp
);
    import ppis_pkg::*;

    ppis_state_t state_reg;
    ppis_state_t state_next;

    // sample state
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [DIFF_W-1:0] prev_error_reg;

    // per transaction working registers
    logic signed [ERR_W-1:0]  e_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    ppis_kind_t               kind_reg;
    logic [THR_W-1:0]         num_reg;
    logic [THR_W-1:0]         den_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     neg_reg;
    logic [ABS_W-1:0]         abs_reg;
    logic [LO_PROD_W-1:0]     frac_lo_reg;

    // output register
    logic                     m_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    // combinational helpers
    logic [ERR_W-1:0]         mag_c;
    logic [ERR_W-1:0]         begin_c;
    logic [ERR_W-1:0]         full_c;
    ppis_kind_t               kind_c;
    logic                     accumulate_c;
    logic signed [SUM_W:0]    sum_c;
    logic signed [SUM_W:0]    ilim_c;
    logic signed [SUM_W:0]    sum_clamp_c;
    logic [ERR_W-1:0]         num_wide_c;
    logic signed [ACC_W-1:0]  prod_acc_c;
    logic [PROD_W-1:0]        abs_c;
    logic signed [ACC_W-1:0]  quot_c;
    logic signed [ACC_W-1:0]  dlim_c;
    logic signed [ACC_W-1:0]  drive_clamp_c;
    logic                     out_free;

    // error magnitude and separation band
    always_comb begin
        mag_c   = e_reg[ERR_W-1] ? ERR_W'(-e_reg) : ERR_W'(e_reg);
        begin_c = ERR_W'(cfg.begin_threshold);
        full_c  = ERR_W'(cfg.full_threshold);
        accumulate_c = 1'b1;
        kind_c       = KIND_FULL;
        if (cfg.separation_enable) begin
            if (mag_c > begin_c) begin
                accumulate_c = 1'b0;
                kind_c       = KIND_ZERO;
            end else if (mag_c < full_c) begin
                kind_c = KIND_FULL;
            end else if (begin_c > full_c) begin
                kind_c = KIND_FRAC;
            end else begin
                kind_c = KIND_FULL;
            end
        end
        num_wide_c = begin_c - mag_c;
    end

    // integral update with symmetric clamp
    always_comb begin
        if (accumulate_c) begin
            sum_c = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(e_reg);
        end else begin
            sum_c = (SUM_W+1)'(error_sum_reg);
        end
        ilim_c = $signed({{(SUM_W+1-ILIM_W){1'b0}}, cfg.integral_limit});
        if (sum_c < -ilim_c) begin
            sum_clamp_c = -ilim_c;
        end else if (sum_c > ilim_c) begin
            sum_clamp_c = ilim_c;
        end else begin
            sum_clamp_c = sum_c;
        end
    end

    // product views, quotient and output clamp
    always_comb begin
        prod_acc_c = $signed(mul_prod[ACC_W-1:0]);
        abs_c      = mul_prod[PROD_W-1] ? PROD_W'(-mul_prod) : PROD_W'(mul_prod);
        quot_c     = $signed({{(ACC_W-ABS_W){1'b0}}, div_rsp.quotient[ABS_W-1:0]});
        dlim_c     = $signed({{(ACC_W-DLIM_W){1'b0}}, cfg.drive_limit});
        if (acc_reg < -dlim_c) begin
            drive_clamp_c = -dlim_c;
        end else if (acc_reg > dlim_c) begin
            drive_clamp_c = dlim_c;
        end else begin
            drive_clamp_c = acc_reg;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_SUM;
            ST_SUM:       state_next = ST_MUL_P;
            ST_MUL_P:     state_next = ST_MUL_D;
            ST_MUL_D:     state_next = ST_MUL_I;
            ST_MUL_I:     state_next = ST_I_TERM;
            ST_I_TERM:    state_next = (kind_reg == KIND_FRAC) ? ST_FRAC_LO : ST_OUT;
            ST_FRAC_LO:   state_next = ST_FRAC_HI;
            ST_FRAC_HI:   state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs: handshake, multiplier operands, divider start
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        mul_req.a    = '0;
        mul_req.b    = '0;
        div_req.start    = (state_reg == ST_DIV_START);
        div_req.dividend = {mul_prod[DIV_W-LO_SHIFT-1:0], {LO_SHIFT{1'b0}}}
                           + DIV_W'(frac_lo_reg);
        div_req.divisor  = den_reg;
        case (state_reg)
            ST_MUL_P: begin
                mul_req.a = MUL_W'(cfg.gain_p);
                mul_req.b = MUL_W'(e_reg);
            end
            ST_MUL_D: begin
                mul_req.a = MUL_W'(cfg.gain_d);
                mul_req.b = MUL_W'(diff_reg);
            end
            ST_MUL_I: begin
                mul_req.a = MUL_W'(cfg.gain_i);
                mul_req.b = MUL_W'(error_sum_reg);
            end
            ST_FRAC_LO: begin
                mul_req.a = $signed({1'b0, abs_reg[LO_SHIFT-1:0]});
                mul_req.b = $signed({{(MUL_W-THR_W){1'b0}}, num_reg});
            end
            ST_FRAC_HI: begin
                mul_req.a = $signed({{(MUL_W-(ABS_W-LO_SHIFT)){1'b0}},
                                     abs_reg[ABS_W-1:LO_SHIFT]});
                mul_req.b = $signed({{(MUL_W-THR_W){1'b0}}, num_reg});
            end
            default: begin
            end
        endcase
    end

    // state, sample state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            error_sum_reg  <= '0;
            prev_error_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SUM) begin
                error_sum_reg  <= sum_clamp_c[SUM_W-1:0];
                prev_error_reg <= DIFF_W'(e_reg);
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // working datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    e_reg <= ERR_W'(target) - ERR_W'(measured);
                end
            end
            ST_SUM: begin
                diff_reg <= DIFF_W'(e_reg) - prev_error_reg;
                kind_reg <= kind_c;
                num_reg  <= num_wide_c[THR_W-1:0];
                den_reg  <= cfg.begin_threshold - cfg.full_threshold;
            end
            ST_MUL_D: begin
                acc_reg <= prod_acc_c;
            end
            ST_MUL_I: begin
                acc_reg <= acc_reg + prod_acc_c;
            end
            ST_I_TERM: begin
                neg_reg <= mul_prod[PROD_W-1];
                abs_reg <= abs_c[ABS_W-1:0];
                if (kind_reg == KIND_FULL) begin
                    acc_reg <= acc_reg + prod_acc_c;
                end
            end
            ST_FRAC_HI: begin
                frac_lo_reg <= mul_prod[LO_PROD_W-1:0];
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    acc_reg <= neg_reg ? acc_reg - quot_c : acc_reg + quot_c;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    drive_reg <= drive_clamp_c[DRIVE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign drive   = drive_reg;

endmodule

FILE: rtl/core/positional_pid_integral_separation.sv
// Positional PID controller with integral separation. Each input transaction carries a
// target and a measured sample; the block forms the error, updates the clamped error
// integral, and returns one clamped drive value per transaction. All P, I and D products
// run through one shared 33x33 multiplier under a small sequencer, so s_axis_tready is
// low while a transaction is in work. With the full or zero integral term a transaction
// passes the sum, P, D and I product, I-term and output steps before the next one can be
// accepted; in the middle separation band it also waits on the serial divider that forms
// the linear fraction one quotient bit per cycle over a 79-bit dividend. A finished
// result waits in an output register, so the next transaction is taken while it is
// still unread; a result that finishes while the previous one is still unread waits
// for it. Registers sit on the APB port at byte address 8*index; the state after reset
// needs no clearing pass.
// depends on ppis_pkg, ppis_regs, ppis_mul, ppis_div and ppis_ctrl
module positional_pid_integral_separation (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: target [15:0], measured [31:16]
    input  logic [ppis_pkg::S_DATA_W-1:0]    s_axis_tdata,
    // result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: drive [47:0]
    output logic [ppis_pkg::M_DATA_W-1:0]    m_axis_tdata,
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ppis_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ppis_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ppis_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import ppis_pkg::*;

    ppis_cfg_t                cfg;
    ppis_mul_req_t            mul_req;
    logic signed [PROD_W-1:0] mul_prod;
    ppis_div_req_t            div_req;
    ppis_div_rsp_t            div_rsp;
    logic signed [SAMPLE_BITS-1:0] target;
    logic signed [SAMPLE_BITS-1:0] measured;
    logic signed [DRIVE_W-1:0]     drive;

    // unpack and pack the stream payloads
    assign target       = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign measured     = $signed(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign m_axis_tdata = M_DATA_W'($unsigned(drive));

    // configuration registers
    ppis_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // shared multiplier
    ppis_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    // serial divider for the separation fraction
    ppis_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // sequencer and datapath
    ppis_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .target   (target),
        .measured (measured),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .drive    (drive),
        .mul_req  (mul_req),
        .mul_prod (mul_prod),
        .div_req  (div_req),
        .div_rsp  (div_rsp)
    );

endmodule

FILE: rtl/core/ppis_checker.sv
// port-level checker for the positional pid block, bound to the top level
// depends on ppis_pkg and positional_pid_integral_separation_macros.svh
`include "positional_pid_integral_separation_macros.svh"

module ppis_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [ppis_pkg::M_DATA_W-1:0]   m_axis_tdata
);
    import ppis_pkg::*;

    // block is busy right after taking a transaction
    `PPIS_ASSERT_NEXT(busy_after_accept, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a result never appears the cycle after acceptance
    `PPIS_ASSERT_NEXT(no_instant_result, aclk, aresetn,
        s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid))

    // stalled result holds
    `PPIS_ASSERT_NEXT(result_holds, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // result leaves only through a completed transaction
    `PPIS_ASSERT_SAME(result_drops_on_take, aclk, aresetn,
        $fell(m_axis_tvalid), $past(m_axis_tready))

endmodule

bind positional_pid_integral_separation ppis_checker u_checker (.*);

FILE: tb/sv/testbench.sv
// self-checking testbench for positional_pid_integral_separation: a fixed stimulus table,
// then random samples under randomly chosen controller settings and handshake idling
// depends on ppis_pkg and the positional_pid_integral_separation rtl
`timescale 1ns / 1ps

module testbench;
    import ppis_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 120;
    localparam int SEGMENT_ITEMS  = 34;

    // one row of the fixed stimulus table
    typedef struct packed {
        logic [2:0]        set;
        logic signed [15:0] tgt;
        logic signed [15:0] meas;
        logic              fixed;
        logic [47:0]       drive;
    } directed_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // tdata: target [15:0], measured [31:16]
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // tdata: drive [47:0]
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // controller shadow state
    ppis_cfg_t cfg_shadow = '0;
    longint integral_sum = 0;
    longint last_error = 0;
    logic [47:0] drive_expected_q[$];

    int fail_count = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // settings: gain_p, gain_i, gain_d, integral_limit, drive_limit, enable, begin, full
    ppis_cfg_t directed_settings [6] = '{
        '{32'h0, 32'h0, 32'h0, 31'h0, 47'h0, 1'b0, 16'd0, 16'd0},
        '{32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 47'h7FFF_FFFF_FFFF,
          1'b1, 16'd1000, 16'd100},
        '{32'h8000_0000, 32'h0000_8000, 32'hFFFF_0000, 31'd3, 47'd12345,
          1'b1, 16'd500, 16'd500},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 47'h0,
          1'b0, 16'd65535, 16'd0},
        '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_8000, 31'd100000, 47'h7FFF_FFFF_FFFF,
          1'b1, 16'd65535, 16'd0},
        '{32'h0000_0100, 32'h0001_0000, 32'h0, 31'h7FFF_FFFF, 47'h7FFF_FFFF_FFFF,
          1'b1, 16'd0, 16'd0}
    };

    // set, target, measured, fixed expectation, drive
    directed_row_t directed_rows [24] = '{
        // reset settings: all gains zero
        '{3'd0, 16'sd32767, 16'h8000, 1'b1, 48'd0},
        '{3'd0, 16'h8000, 16'sd32767, 1'b1, 48'd0},
        '{3'd0, 16'sd0, 16'sd0, 1'b1, 48'd0},
        // full band, band edges, frozen integral, largest error swing
        '{3'd1, 16'sd50, 16'sd0, 1'b0, 48'd0},
        '{3'd1, 16'sd0, -16'sd100, 1'b0, 48'd0},
        '{3'd1, -16'sd500, 16'sd0, 1'b0, 48'd0},
        '{3'd1, 16'sd1000, 16'sd0, 1'b0, 48'd0},
        '{3'd1, 16'sd0, 16'sd1001, 1'b0, 48'd0},
        '{3'd1, 16'sd32767, 16'h8000, 1'b0, 48'd0},
        '{3'd1, 16'h8000, 16'sd32767, 1'b0, 48'd0},
        // equal thresholds, tiny integral limit, output clamp
        '{3'd2, 16'sd500, 16'sd0, 1'b0, 48'd0},
        '{3'd2, -16'sd499, 16'sd0, 1'b0, 48'd0},
        '{3'd2, 16'sd0, 16'sd501, 1'b0, 48'd0},
        '{3'd2, 16'sd7, 16'sd0, 1'b0, 48'd0},
        '{3'd2, 16'sd32767, 16'sd32767, 1'b0, 48'd0},
        // zero drive limit forces zero output
        '{3'd3, 16'sd32767, 16'h8000, 1'b1, 48'd0},
        '{3'd3, 16'h8000, 16'sd32767, 1'b1, 48'd0},
        '{3'd3, 16'sd123, -16'sd4567, 1'b1, 48'd0},
        // widest middle band
        '{3'd4, 16'sd0, 16'sd0, 1'b0, 48'd0},
        '{3'd4, 16'h8000, 16'sd32767, 1'b0, 48'd0},
        '{3'd4, 16'sd30000, -16'sd2000, 1'b0, 48'd0},
        // zero thresholds: any error freezes the integral
        '{3'd5, 16'sd0, 16'sd0, 1'b0, 48'd0},
        '{3'd5, 16'sd1, 16'sd0, 1'b0, 48'd0},
        '{3'd5, 16'h8000, 16'h8000, 1'b0, 48'd0}
    };

    positional_pid_integral_separation i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 aclk = ~aclk;

    // expected drive for one sample; advances the shadow integral and last error
    function automatic logic [47:0] predict_drive(input logic signed [15:0] tgt,
                                                  input logic signed [15:0] meas);
        longint err, mag, bt, ft, gp, gi, gd, lim, i_full, i_term, total;
        longint unsigned num, den, a, scaled;
        ppis_kind_t kind;
        bit accumulate;
        err = longint'(tgt) - longint'(meas);
        mag = (err < 0) ? -err : err;
        bt = longint'(cfg_shadow.begin_threshold);
        ft = longint'(cfg_shadow.full_threshold);
        gp = longint'($signed(cfg_shadow.gain_p));
        gi = longint'($signed(cfg_shadow.gain_i));
        gd = longint'($signed(cfg_shadow.gain_d));
        kind = KIND_FULL;
        accumulate = 1'b1;
        // separation bands by error magnitude
        if (cfg_shadow.separation_enable) begin
            if (mag > bt) begin
                accumulate = 1'b0;
                kind = KIND_ZERO;
            end else if (mag >= ft && bt > ft) begin
                kind = KIND_FRAC;
            end
        end
        // integral update and clamp
        if (accumulate)
            integral_sum = integral_sum + err;
        lim = longint'(cfg_shadow.integral_limit);
        if (integral_sum > lim)
            integral_sum = lim;
        else if (integral_sum < -lim)
            integral_sum = -lim;
        // integral term, fraction truncated toward zero
        i_full = gi * integral_sum;
        case (kind)
            KIND_ZERO: i_term = 0;
            KIND_FULL: i_term = i_full;
            default: begin
                num = bt - mag;
                den = bt - ft;
                a = (i_full < 0) ? -i_full : i_full;
                scaled = (a / den) * num + ((a % den) * num) / den;
                i_term = (i_full < 0) ? -longint'(scaled) : longint'(scaled);
            end
        endcase
        // sum and output clamp
        total = gp * err + i_term + gd * (err - last_error);
        lim = longint'(cfg_shadow.drive_limit);
        if (total > lim)
            total = lim;
        else if (total < -lim)
            total = -lim;
        last_error = err;
        return total[47:0];
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return 32'(int'($urandom_range(0, 524288)) - 262144);
            default: return $urandom();
        endcase
    endfunction

    function automatic ppis_cfg_t random_settings();
        ppis_cfg_t c;
        c.gain_p = random_gain();
        c.gain_i = random_gain();
        c.gain_d = random_gain();
        case ($urandom_range(4))
            0: c.integral_limit = '0;
            1: c.integral_limit = '1;
            2: c.integral_limit = 31'($urandom_range(0, 50));
            3: c.integral_limit = 31'($urandom_range(0, 100000));
            default: c.integral_limit = 31'($urandom());
        endcase
        case ($urandom_range(7))
            0: c.drive_limit = '0;
            1, 2: c.drive_limit = '1;
            3: c.drive_limit = 47'($urandom_range(0, 16777216));
            default: c.drive_limit = 47'({$urandom(), $urandom()});
        endcase
        c.separation_enable = ($urandom_range(3) != 0);
        case ($urandom_range(5))
            0: c.begin_threshold = '0;
            1: c.begin_threshold = '1;
            2: c.begin_threshold = 16'($urandom_range(0, 65535));
            default: c.begin_threshold = 16'($urandom_range(1, 2000));
        endcase
        case ($urandom_range(5))
            0: c.full_threshold = c.begin_threshold;
            1: c.full_threshold = '0;
            2: c.full_threshold = 16'($urandom_range(0, 65535));
            default: c.full_threshold = 16'($urandom_range(0, c.begin_threshold));
        endcase
        return c;
    endfunction

    // measured in the upper half, target in the lower; errors mostly near the bands
    function automatic logic [31:0] random_pair();
        int span, err_want, meas, tgt;
        if ($urandom_range(9) < 3)
            return $urandom();
        span = int'(cfg_shadow.begin_threshold);
        err_want = int'($urandom_range(0, span + span / 4 + 10));
        if ($urandom_range(1))
            err_want = -err_want;
        meas = int'($signed(16'($urandom())));
        tgt = meas + err_want;
        if (tgt > 32767)
            tgt = 32767;
        else if (tgt < -32768)
            tgt = -32768;
        return {16'(meas), 16'(tgt)};
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("ERROR at %0t: %s: got 0x%012h, expected 0x%012h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic write_register(input ppis_reg_idx_t idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, {REG_IDX_LSB{1'b0}}};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    // all eight registers, back to back, then the bus goes idle
    task automatic load_settings(input ppis_cfg_t c);
        write_register(REG_GAIN_P, {32'b0, c.gain_p});
        write_register(REG_GAIN_I, {32'b0, c.gain_i});
        write_register(REG_GAIN_D, {32'b0, c.gain_d});
        write_register(REG_INTEGRAL_LIMIT, {33'b0, c.integral_limit});
        write_register(REG_DRIVE_LIMIT, {17'b0, c.drive_limit});
        write_register(REG_SEPARATION_ENABLE, {63'b0, c.separation_enable});
        write_register(REG_BEGIN_THRESHOLD, {48'b0, c.begin_threshold});
        write_register(REG_FULL_THRESHOLD, {48'b0, c.full_threshold});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_shadow = c;
    endtask

    // stop sending and wait until every expected drive has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (drive_expected_q.size() != 0)
            @(posedge aclk);
    endtask

    // one input transaction, optional idle gap in front
    task automatic send_sample(input logic signed [15:0] tgt, input logic signed [15:0] meas,
                               input logic fixed, input logic [47:0] fixed_drive);
        logic [47:0] predicted;
        if (int'($urandom_range(99)) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {meas, tgt};
        do @(posedge aclk); while (!s_axis_tready);
        predicted = predict_drive(tgt, meas);
        drive_expected_q.push_back(fixed ? fixed_drive : predicted);
    endtask

    // result checking and random backpressure
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (drive_expected_q.size() == 0)
                report_mismatch("result with no expectation", m_axis_tdata[47:0], 48'd0);
            else if (m_axis_tdata[47:0] !== drive_expected_q[0])
                report_mismatch("drive", m_axis_tdata[47:0], drive_expected_q.pop_front());
            else
                void'(drive_expected_q.pop_front());
        end
        m_axis_tready <= (int'($urandom_range(99)) >= recv_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [31:0] pair;
        int current_set;
        current_set = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed_rows[n]) begin
            if (int'(directed_rows[n].set) != current_set) begin
                drain_results();
                current_set = int'(directed_rows[n].set);
                load_settings(directed_settings[current_set]);
            end
            send_sample(directed_rows[n].tgt, directed_rows[n].meas, directed_rows[n].fixed,
                        directed_rows[n].drive);
        end

        // random part: three idling phases, four settings each
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 22;
                    recv_idle_pct = 81;
                end
                1: begin
                    send_idle_pct = 81;
                    recv_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                drain_results();
                load_settings(random_settings());
                repeat (SEGMENT_ITEMS) begin
                    pair = random_pair();
                    send_sample(pair[15:0], pair[31:16], 1'b0, 48'd0);
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
